/* hw/rtl/complex_arith_unit_assert.svh */
// assertion macros used by the checker file of the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cau_pkg.sv */
// types and constants of the complex arithmetic unit
package cau_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC       = 8;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int MAG_W      = 2 * DATA_W;
    localparam int QUO_W      = DATA_W + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int IN_DATA_W  = 4 * DATA_W;
    localparam int OUT_DATA_W = 2 * DATA_W;

    localparam logic [MAG_W-1:0]  NEG_LIM = MAG_W'(1) << (DATA_W - 1);
    localparam logic [MAG_W-1:0]  POS_LIM = NEG_LIM - MAG_W'(1);
    localparam logic [DATA_W-1:0] SAT_MAX = POS_LIM[DATA_W-1:0];
    localparam logic [DATA_W-1:0] SAT_MIN = NEG_LIM[DATA_W-1:0];

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } in_t;

    // sign/magnitude item as it walks through the divider steps;
    // rem holds the magnitude (shifted down by FRAC for multiply) for every operation but divide
    typedef struct packed {
        op_t              op;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic             ovf_re;
        logic             ovf_im;
        logic [MAG_W-1:0] rem_re;
        logic [MAG_W-1:0] rem_im;
        logic [QUO_W-1:0] acc_re;
        logic [QUO_W-1:0] acc_im;
        logic [MAG_W-1:0] den;
    } div_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        status_t                  status;
    } out_t;

endpackage

/* hw/rtl/complex_arith_unit.sv */
// top level of the complex arithmetic unit
//
//   channel   | direction | tdata                          | tuser
//   s_axis    | in        | a_re, a_im, b_re, b_im         | operation
//   m_axis    | out       | res_re, res_im                 | status
//
// one request per cycle sustained while the output is not stalled
// the pipeline holds the 17 one-bit divider steps plus four front stages and the output stage
// every operation runs through all stages so results leave in request order
// reset clears the stage valid bits only
// a stage takes a new request when it is empty or the stage after it moves on,
// so bubbles close up while the output is stalled
module complex_arith_unit import cau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]            s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // res_re, res_im
    output logic [1:0]            m_axis_tuser   // status
);

    in_t  in_data;
    out_t res;
    div_t div_data  [DIV_STEPS+1];
    logic div_valid [DIV_STEPS+1];
    logic div_ready [DIV_STEPS+1];

    assign in_data.op   = op_t'(s_axis_tuser);
    assign in_data.a_re = s_axis_tdata[DATA_W-1:0];
    assign in_data.a_im = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign in_data.b_re = s_axis_tdata[3*DATA_W-1:2*DATA_W];
    assign in_data.b_im = s_axis_tdata[4*DATA_W-1:3*DATA_W];

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        cau_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    cau_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STEPS]),
        .in_ready  (div_ready[DIV_STEPS]),
        .in_data   (div_data[DIV_STEPS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {res.res_im, res.res_re};
    assign m_axis_tuser = res.status;

endmodule

/* hw/rtl/cau_front.sv */
// front end: products, sums, sign/magnitude split and divider setup, four stages
module cau_front import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    typedef struct packed {
        op_t                      op;
        logic                     dz;
        logic signed [PROD_W-1:0] ac;
        logic signed [PROD_W-1:0] bd;
        logic signed [PROD_W-1:0] ad;
        logic signed [PROD_W-1:0] bc;
        logic signed [PROD_W-1:0] cc;
        logic signed [PROD_W-1:0] dd;
        logic signed [DATA_W:0]   sum_re;
        logic signed [DATA_W:0]   sum_im;
    } prod_t;

    typedef struct packed {
        op_t                    op;
        logic                   dz;
        logic signed [PROD_W:0] val_re;
        logic signed [PROD_W:0] val_im;
        logic [MAG_W-1:0]       den;
    } comb_t;

    typedef struct packed {
        op_t              op;
        logic             dz;
        logic             neg_re;
        logic             neg_im;
        logic [MAG_W-1:0] mag_re;
        logic [MAG_W-1:0] mag_im;
        logic [MAG_W-1:0] den;
    } smag_t;

    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  rdy1, rdy2, rdy3, rdy4;
    prod_t p_reg, p_next;
    comb_t c_reg, c_next;
    smag_t m_reg, m_next;
    div_t  d_reg, d_next;

    logic signed [PROD_W:0]   abs_re, abs_im;
    logic [MAG_W+FRAC-1:0]    dvd_re, dvd_im;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: six products and the add/subtract sums
    always_comb
    begin
        p_next.op     = in_data.op;
        p_next.dz     = (in_data.b_re == '0) && (in_data.b_im == '0);
        p_next.ac     = in_data.a_re * in_data.b_re;
        p_next.bd     = in_data.a_im * in_data.b_im;
        p_next.ad     = in_data.a_re * in_data.b_im;
        p_next.bc     = in_data.a_im * in_data.b_re;
        p_next.cc     = in_data.b_re * in_data.b_re;
        p_next.dd     = in_data.b_im * in_data.b_im;
        p_next.sum_re = (in_data.op == OP_SUB) ? in_data.a_re - in_data.b_re
                                               : in_data.a_re + in_data.b_re;
        p_next.sum_im = (in_data.op == OP_SUB) ? in_data.a_im - in_data.b_im
                                               : in_data.a_im + in_data.b_im;
    end

    // stage 2: combine products per operation
    always_comb
    begin
        c_next.op  = p_reg.op;
        c_next.dz  = p_reg.dz;
        c_next.den = $unsigned(p_reg.cc) + $unsigned(p_reg.dd);
        case (p_reg.op)
            OP_MUL:
            begin
                c_next.val_re = p_reg.ac - p_reg.bd;
                c_next.val_im = p_reg.ad + p_reg.bc;
            end
            OP_DIV:
            begin
                c_next.val_re = p_reg.ac + p_reg.bd;
                c_next.val_im = p_reg.bc - p_reg.ad;
            end
            default:
            begin
                c_next.val_re = (PROD_W+1)'(p_reg.sum_re);
                c_next.val_im = (PROD_W+1)'(p_reg.sum_im);
            end
        endcase
    end

    // stage 3: sign and magnitude
    always_comb
    begin
        abs_re        = c_reg.val_re[PROD_W] ? -c_reg.val_re : c_reg.val_re;
        abs_im        = c_reg.val_im[PROD_W] ? -c_reg.val_im : c_reg.val_im;
        m_next.op     = c_reg.op;
        m_next.dz     = c_reg.dz;
        m_next.den    = c_reg.den;
        m_next.neg_re = c_reg.val_re[PROD_W];
        m_next.neg_im = c_reg.val_im[PROD_W];
        m_next.mag_re = abs_re[MAG_W-1:0];
        m_next.mag_im = abs_im[MAG_W-1:0];
    end

    // stage 4: truncate products, split the dividend and flag quotient overflow
    always_comb
    begin
        dvd_re        = {m_reg.mag_re, {FRAC{1'b0}}};
        dvd_im        = {m_reg.mag_im, {FRAC{1'b0}}};
        d_next.op     = m_reg.op;
        d_next.dz     = m_reg.dz;
        d_next.neg_re = m_reg.neg_re;
        d_next.neg_im = m_reg.neg_im;
        d_next.den    = m_reg.den;
        d_next.ovf_re = 1'b0;
        d_next.ovf_im = 1'b0;
        d_next.acc_re = '0;
        d_next.acc_im = '0;
        case (m_reg.op)
            OP_DIV:
            begin
                // high part must stay below the divisor or the quotient needs > QUO_W bits
                d_next.rem_re = MAG_W'(dvd_re[MAG_W+FRAC-1:QUO_W]);
                d_next.rem_im = MAG_W'(dvd_im[MAG_W+FRAC-1:QUO_W]);
                d_next.acc_re = dvd_re[QUO_W-1:0];
                d_next.acc_im = dvd_im[QUO_W-1:0];
                d_next.ovf_re = MAG_W'(dvd_re[MAG_W+FRAC-1:QUO_W]) >= m_reg.den;
                d_next.ovf_im = MAG_W'(dvd_im[MAG_W+FRAC-1:QUO_W]) >= m_reg.den;
            end
            OP_MUL:
            begin
                d_next.rem_re = m_reg.mag_re >> FRAC;
                d_next.rem_im = m_reg.mag_im >> FRAC;
            end
            default:
            begin
                d_next.rem_re = m_reg.mag_re;
                d_next.rem_im = m_reg.mag_im;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            p_reg <= p_next;
        if (rdy2 && v1_reg)
            c_reg <= c_next;
        if (rdy3 && v2_reg)
            m_reg <= m_next;
        if (rdy4 && v3_reg)
            d_reg <= d_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = d_reg;

endmodule

/* hw/rtl/cau_div_step.sv */
// one restoring division step for both parts of the quotient
module cau_div_step import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    logic           v_reg;
    div_t           d_reg, d_next;
    logic [MAG_W:0] trial_re, trial_im;
    logic           take_re, take_im;
    logic           active;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        active   = (in_data.op == OP_DIV) && !in_data.dz;
        // shift the next dividend bit into the partial remainder
        trial_re = {in_data.rem_re, in_data.acc_re[QUO_W-1]};
        trial_im = {in_data.rem_im, in_data.acc_im[QUO_W-1]};
        take_re  = trial_re >= {1'b0, in_data.den};
        take_im  = trial_im >= {1'b0, in_data.den};
        d_next   = in_data;
        if (active && !in_data.ovf_re)
        begin
            d_next.rem_re = take_re ? MAG_W'(trial_re - {1'b0, in_data.den})
                                    : trial_re[MAG_W-1:0];
            d_next.acc_re = {in_data.acc_re[QUO_W-2:0], take_re};
        end
        if (active && !in_data.ovf_im)
        begin
            d_next.rem_im = take_im ? MAG_W'(trial_im - {1'b0, in_data.den})
                                    : trial_im[MAG_W-1:0];
            d_next.acc_im = {in_data.acc_im[QUO_W-2:0], take_im};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

/* hw/rtl/cau_sat.sv */
// output stage: saturate, encode two's complement and set the status
module cau_sat import cau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic             v_reg;
    out_t             r_reg, r_next;
    logic [MAG_W-1:0] mag_re, mag_im;
    logic             sat_re, sat_im;
    logic [DATA_W:0]  enc_re, enc_im;

    // returns {saturated, value}
    function automatic logic [DATA_W:0] encode(input logic neg, input logic [MAG_W-1:0] mag);
        logic [DATA_W-1:0] low;
        low = mag[DATA_W-1:0];
        if (neg)
        begin
            if (mag > NEG_LIM)
                return {1'b1, SAT_MIN};
            return {1'b0, -low};
        end
        if (mag > POS_LIM)
            return {1'b1, SAT_MAX};
        return {1'b0, low};
    endfunction

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        if (in_data.op == OP_DIV)
        begin
            mag_re = in_data.ovf_re ? '1 : MAG_W'(in_data.acc_re);
            mag_im = in_data.ovf_im ? '1 : MAG_W'(in_data.acc_im);
        end
        else
        begin
            mag_re = in_data.rem_re;
            mag_im = in_data.rem_im;
        end
        enc_re = encode(in_data.neg_re, mag_re);
        enc_im = encode(in_data.neg_im, mag_im);
        sat_re = enc_re[DATA_W];
        sat_im = enc_im[DATA_W];
        if (in_data.op == OP_DIV && in_data.dz)
        begin
            r_next.res_re = '0;
            r_next.res_im = '0;
            r_next.status = ST_DZ;
        end
        else
        begin
            r_next.res_re = enc_re[DATA_W-1:0];
            r_next.res_im = enc_im[DATA_W-1:0];
            r_next.status = (sat_re || sat_im) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            r_reg <= r_next;
    end

    assign out_valid = v_reg;
    assign out_data  = r_reg;

endmodule

/* hw/rtl/cau_checker.sv */
// port-level checks on the result stream of the complex arithmetic unit
`include "complex_arith_unit_assert.svh"

module cau_checker import cau_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [1:0]            m_axis_tuser
);

    `CAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // divide by zero gives an all-zero result
    `CAU_ASSERT_IMPL(a_dz_zero, m_axis_tvalid && m_axis_tuser == ST_DZ, m_axis_tdata == '0, "divide by zero result not zero")

    // saturation status needs a part pinned at a limit
    `CAU_ASSERT_IMPL(a_sat_limit, m_axis_tvalid && m_axis_tuser == ST_SAT, m_axis_tdata[DATA_W-1:0] == SAT_MAX || m_axis_tdata[DATA_W-1:0] == SAT_MIN || m_axis_tdata[2*DATA_W-1:DATA_W] == SAT_MAX || m_axis_tdata[2*DATA_W-1:DATA_W] == SAT_MIN, "saturation flagged without a clamped part")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/complex_arith_unit_test.sv */
// self-checking stream testbench for the complex arithmetic unit
module complex_arith_unit_test import cau_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 6;
    localparam int PIPE_WAIT   = 40;    // pipeline depth plus margin
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 450;
    localparam int N_ROWS      = 24;

    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] ar;
        logic [DATA_W-1:0] ai;
        logic [DATA_W-1:0] br;
        logic [DATA_W-1:0] bi;
        bit                given;
        logic [DATA_W-1:0] er;
        logic [DATA_W-1:0] ei;
        status_t           es;
    } vector_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // a_re, a_im, b_re, b_im
    logic [1:0]            s_axis_tuser = '0;   // operation
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // res_re, res_im
    logic [1:0]            m_axis_tuser;        // status

    out_t pending_results [$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   op_count [4] = '{0, 0, 0, 0};
    int   status_count [3] = '{0, 0, 0};

    // given expectations only where they can be read off directly
    vector_row_t directed_rows [N_ROWS] = '{
        '{OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK},
        '{OP_ADD, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001, 1'b1, 16'h7fff, 16'h7fff, ST_SAT},
        '{OP_ADD, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 1'b1, 16'h8000, 16'h8000, ST_SAT},
        '{OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1'b1, 16'h8000, 16'h7fff, ST_SAT},
        '{OP_SUB, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 16'h0000, 16'h0000, ST_OK},
        '{OP_ADD, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 1'b1, 16'h0000, 16'h0000, ST_OK},
        '{OP_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1, 16'h0100, 16'h0000, ST_OK},
        '{OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h7fff, ST_SAT},
        '{OP_MUL, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 1'b1, 16'h7fff, 16'h0000, ST_SAT},
        '{OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK},
        '{OP_MUL, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 1'b1, 16'hff00, 16'h0000, ST_OK},
        '{OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_DZ},
        '{OP_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_DZ},
        '{OP_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1, 16'h0100, 16'h0000, ST_OK},
        '{OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1'b1, 16'h7fff, 16'h7fff, ST_SAT},
        '{OP_DIV, 16'h8000, 16'h0000, 16'h0001, 16'h0000, 1'b1, 16'h8000, 16'h0000, ST_SAT},
        '{OP_DIV, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h0000, ST_OK},
        '{OP_DIV, 16'hffff, 16'h0000, 16'h0100, 16'h0000, 1'b1, 16'hffff, 16'h0000, ST_OK},
        '{OP_MUL, 16'h1234, 16'hfedc, 16'h0567, 16'h89ab, 1'b0, 16'h0000, 16'h0000, ST_OK},
        '{OP_DIV, 16'h0300, 16'hfd00, 16'h0080, 16'h0040, 1'b0, 16'h0000, 16'h0000, ST_OK},
        '{OP_DIV, 16'h0001, 16'h0001, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, ST_OK},
        '{OP_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, 16'h0000, 16'h0000, ST_OK},
        '{OP_SUB, 16'h4000, 16'hc000, 16'hc000, 16'h4000, 1'b0, 16'h0000, 16'h0000, ST_OK},
        '{OP_DIV, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 1'b0, 16'h0000, 16'h0000, ST_OK}
    };

    complex_arith_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // top bit flags a clamp
    function automatic logic [DATA_W:0] clip_part(input longint v);
        if (v > longint'(POS_LIM))
            return {1'b1, SAT_MAX};
        if (v < -longint'(NEG_LIM))
            return {1'b1, SAT_MIN};
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    function automatic out_t complex_result(input op_t op, input longint ar, input longint ai,
                                            input longint br, input longint bi);
        longint          re;
        longint          im;
        longint          den;
        logic [DATA_W:0] cre;
        logic [DATA_W:0] cim;
        out_t            r;
        re = 0;
        im = 0;
        den = br * br + bi * bi;
        case (op)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
                // drop fraction bits toward zero
                re = (re < 0) ? -((-re) >>> FRAC) : (re >>> FRAC);
                im = (im < 0) ? -((-im) >>> FRAC) : (im >>> FRAC);
            end
            default:
            begin
                if (den == 0)
                begin
                    r.res_re = '0;
                    r.res_im = '0;
                    r.status = ST_DZ;
                    return r;
                end
                // signed division truncates toward zero
                re = ((ar * br + ai * bi) <<< FRAC) / den;
                im = ((ai * br - ar * bi) <<< FRAC) / den;
            end
        endcase
        cre = clip_part(re);
        cim = clip_part(im);
        r.res_re = cre[DATA_W-1:0];
        r.res_im = cim[DATA_W-1:0];
        r.status = (cre[DATA_W] || cim[DATA_W]) ? ST_SAT : ST_OK;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    3: return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            1, 2: return 16'($urandom_range(2048)) - 16'd1024;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input op_t op, input logic [DATA_W-1:0] ar,
                                input logic [DATA_W-1:0] ai, input logic [DATA_W-1:0] br,
                                input logic [DATA_W-1:0] bi, input bit given,
                                input out_t given_result);
        out_t want;
        want = given ? given_result
                     : complex_result(op, signed'(ar), signed'(ai), signed'(br), signed'(bi));
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bi, br, ai, ar};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(want);
        op_count[op]++;
        @(negedge clk);
    endtask

    task automatic send_random_request();
        op_t               op;
        logic [DATA_W-1:0] ar;
        logic [DATA_W-1:0] ai;
        logic [DATA_W-1:0] br;
        logic [DATA_W-1:0] bi;
        op = op_t'($urandom_range(3));
        ar = pick_operand();
        ai = pick_operand();
        br = pick_operand();
        bi = pick_operand();
        if ($urandom_range(19) == 0)
        begin
            br = '0;
            bi = '0;
        end
        send_request(op, ar, ai, br, bi, 1'b0, '0);
    endtask

    // hold requests back until the pipeline has handed out everything
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        out_t got;
        out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.res_re = m_axis_tdata[DATA_W-1:0];
            got.res_im = m_axis_tdata[2*DATA_W-1:DATA_W];
            got.status = status_t'(m_axis_tuser);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result re %h im %h status %0d",
                         $time, got.res_re, got.res_im, got.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.res_re !== want.res_re)
                begin
                    $display("%0t: res_re expected %h got %h", $time, want.res_re, got.res_re);
                    error_count++;
                end
                if (got.res_im !== want.res_im)
                begin
                    $display("%0t: res_im expected %h got %h", $time, want.res_im, got.res_im);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (want.status <= ST_DZ)
                    status_count[want.status]++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("complex_arith_unit_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int send_pct [4];
        int stall_pct [4];
        out_t given_result;
        send_pct  = '{0, 52, 0, 29};
        stall_pct = '{0, 0, 52, 29};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            given_result.res_re = directed_rows[i].er;
            given_result.res_im = directed_rows[i].ei;
            given_result.status = directed_rows[i].es;
            send_request(directed_rows[i].op, directed_rows[i].ar, directed_rows[i].ai,
                         directed_rows[i].br, directed_rows[i].bi, directed_rows[i].given,
                         given_result);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            repeat (PHASE_ITEMS) send_random_request();
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (PIPE_WAIT) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count++;
        end
        $display("requests sent: add %0d, subtract %0d, multiply %0d, divide %0d",
                 op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
        $display("results seen: in range %0d, clamped %0d, zero divisor %0d; mismatches %0d",
                 status_count[ST_OK], status_count[ST_SAT], status_count[ST_DZ], error_count);
        if (error_count == 0)
            $display("complex_arith_unit_test: clean");
        else
            $display("complex_arith_unit_test: errors");
        $finish;
    end

endmodule
